// ===== sv/kwl_pkg.sv =====
package kwl_pkg;

  // Token kinds.
  localparam logic [4:0] KIND_LPAREN   = 5'd0;
  localparam logic [4:0] KIND_RPAREN   = 5'd1;
  localparam logic [4:0] KIND_SEMI     = 5'd2;
  localparam logic [4:0] KIND_NEWLINE  = 5'd3;
  localparam logic [4:0] KIND_NUMBER   = 5'd4;
  localparam logic [4:0] KIND_IDENT    = 5'd5;
  localparam logic [4:0] KIND_KEYWORD0 = 5'd6;
  localparam logic [4:0] KIND_EOF      = 5'd28;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SLASH = 2'd1;
  localparam logic [1:0] ERR_CHAR  = 2'd2;

  // Register map: word index taken from paddr[2].
  localparam logic REG_FIRST_LINE = 1'b0;
  localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Keyword table: character i sits in bits [8i+7:8i], unused bytes are zero.
  localparam int NUM_KW = 22;
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0074_656C,  // let
    64'h0000_0000_0074_6573,  // set
    64'h0000_0000_0000_6562,  // be
    64'h0000_0000_0000_6F74,  // to
    64'h0000_0074_6E69_7270,  // print
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0065_6C69_6877,  // while
    64'h0000_0000_0000_6F64,  // do
    64'h0000_0000_0064_6E65,  // end
    64'h0000_0000_0000_7369,  // is
    64'h0000_0000_0074_6F6E,  // not
    64'h0000_0000_7373_656C,  // less
    64'h0000_0000_6E61_6874,  // than
    64'h0072_6574_6165_7267,  // greater
    64'h0000_0000_0000_726F,  // or
    64'h0000_006C_6175_7165,  // equal
    64'h0000_0000_7375_6C70,  // plus
    64'h0000_0073_756E_696D,  // minus
    64'h0000_0073_656D_6974,  // times
    64'h0000_0000_7265_766F,  // over
    64'h6576_6974_6167_656E   // negative
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd3, 4'd2, 4'd2, 4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3, 4'd2,
    4'd3, 4'd4, 4'd4, 4'd7, 4'd2, 4'd5, 4'd4, 4'd5, 4'd5, 4'd4, 4'd8
  };

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_ERROR
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_item_t;

  // Results caused by one input item, handed to the output buffer.
  typedef struct packed {
    logic                load;
    logic [1:0]          count;
    out_item_t [2:0]     res;
  } bundle_t;

  // Configuration write toward the scanner.
  typedef struct packed {
    logic        we;
    logic [15:0] value;
  } cfg_wr_t;

  // Identifier or keyword kind; len is zero when the run is too long for any keyword.
  function automatic logic [4:0] kw_classify(input logic [63:0] chars, input logic [3:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (len == KW_LEN[k] && chars == KW_TEXT[k]) begin
        kind = KIND_KEYWORD0 + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

// ===== sv/kwl_core.sv =====
module kwl_core #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  kwl_pkg::in_item_t  item,
  input  kwl_pkg::cfg_wr_t   cfg,
  output kwl_pkg::bundle_t   bundle,
  output logic [15:0]        first_line
);
  import kwl_pkg::*;

  localparam int KW_IW = $clog2(KEYWORD_CHARS);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] rs_r, rs_nxt;
  logic [POSITION_BITS-1:0] rl_r, rl_nxt;
  logic [7:0]               kw_r [KEYWORD_CHARS];
  logic [7:0]               kw_nxt [KEYWORD_CHARS];
  logic [15:0]              line_r, line_nxt;
  logic [15:0]              first_line_r;

  logic [7:0]               c;
  logic                     fin, is_dig, is_alp, is_word, call_idle;
  logic [POSITION_BITS-1:0] pos_inc;
  out_item_t                cand [4];
  logic [3:0]               cvld;
  out_item_t [2:0]          slots;
  logic [2:0]               n;
  logic [1:0]               cnt;

  // Clamp a position or length to the 16-bit output field.
  function automatic logic [15:0] clamp16(input logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+15:0] ext;
    ext = {16'b0, v};
    return (|ext[POSITION_BITS+15:16]) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic out_item_t mk(input logic [4:0] kind, input logic [1:0] err,
                                   input logic [POSITION_BITS-1:0] st,
                                   input logic [POSITION_BITS-1:0] ln,
                                   input logic [15:0] line);
    out_item_t r;
    r.token_kind   = kind;
    r.error_code   = err;
    r.token_start  = clamp16(st);
    r.token_length = clamp16(ln);
    r.line_number  = line;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Keyword lookup on a set of run characters and a run length.
  function automatic logic [4:0] classify(input logic [7:0] kw [KEYWORD_CHARS],
                                          input logic [POSITION_BITS-1:0] rl);
    logic [63:0] chars;
    logic [3:0]  len;
    for (int i = 0; i < 8; i++) begin
      chars[8*i +: 8] = kw[i];
    end
    len = (rl <= POSITION_BITS'(8)) ? rl[3:0] : 4'd0;
    return kw_classify(chars, len);
  endfunction

  assign c       = item.text_byte;
  assign fin     = item.final_byte;
  assign is_dig  = (c >= 8'h30) && (c <= 8'h39);
  assign is_alp  = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_word = is_dig || is_alp || (c == CH_UNDER);
  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + POSITION_BITS'(1);

  // Scanner step: candidate results in output order, then the next state.
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    rs_nxt    = rs_r;
    rl_nxt    = rl_r;
    kw_nxt    = kw_r;
    line_nxt  = line_r;
    call_idle = 1'b0;
    cvld      = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    // Work that depends on the open run.
    unique case (mode_r)
      MODE_NUMBER: begin
        if (is_dig) begin
          if (rl_r != POS_MAX) rl_nxt = rl_r + POSITION_BITS'(1);
        end else begin
          cvld[0]   = 1'b1;
          cand[0]   = mk(KIND_NUMBER, ERR_NONE, rs_r, rl_r, line_r);
          mode_nxt  = MODE_IDLE;
          call_idle = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_word) begin
          if (rl_r < POSITION_BITS'(KEYWORD_CHARS)) kw_nxt[rl_r[KW_IW-1:0]] = c;
          if (rl_r != POS_MAX) rl_nxt = rl_r + POSITION_BITS'(1);
        end else begin
          cvld[0]   = 1'b1;
          cand[0]   = mk(classify(kw_r, rl_r), ERR_NONE, rs_r, rl_r, line_r);
          mode_nxt  = MODE_IDLE;
          call_idle = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = MODE_COMMENT;
        end else begin
          cvld[0]  = 1'b1;
          cand[0]  = mk(KIND_LPAREN, ERR_SLASH, rs_r, POSITION_BITS'(1), line_r);
          mode_nxt = MODE_ERROR;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_LF) begin
          mode_nxt  = MODE_IDLE;
          call_idle = 1'b1;
        end
      end
      MODE_IDLE: begin
        call_idle = 1'b1;
      end
      default: begin
      end
    endcase

    // Byte seen with no run open.
    if (call_idle) begin
      if (c == CH_LPAREN) begin
        cvld[1] = 1'b1;
        cand[1] = mk(KIND_LPAREN, ERR_NONE, pos_r, POSITION_BITS'(1), line_r);
      end else if (c == CH_RPAREN) begin
        cvld[1] = 1'b1;
        cand[1] = mk(KIND_RPAREN, ERR_NONE, pos_r, POSITION_BITS'(1), line_r);
      end else if (c == CH_SEMI) begin
        cvld[1] = 1'b1;
        cand[1] = mk(KIND_SEMI, ERR_NONE, pos_r, POSITION_BITS'(1), line_r);
      end else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
        mode_nxt = MODE_IDLE;
      end else if (c == CH_LF) begin
        cvld[1]  = 1'b1;
        cand[1]  = mk(KIND_NEWLINE, ERR_NONE, pos_r, POSITION_BITS'(1), line_r);
        line_nxt = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;
      end else if (is_dig || is_alp || c == CH_UNDER) begin
        mode_nxt = is_dig ? MODE_NUMBER : MODE_IDENT;
        rs_nxt   = pos_r;
        rl_nxt   = POSITION_BITS'(1);
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
          kw_nxt[i] = '0;
        end
        kw_nxt[0] = c;
      end else if (c == CH_SLASH) begin
        mode_nxt = MODE_SLASH;
        rs_nxt   = pos_r;
        rl_nxt   = POSITION_BITS'(1);
      end else begin
        cvld[1]  = 1'b1;
        cand[1]  = mk(KIND_LPAREN, ERR_CHAR, pos_r, POSITION_BITS'(1), line_r);
        mode_nxt = MODE_ERROR;
      end
    end

    if (mode_r != MODE_ERROR) begin
      pos_nxt = pos_inc;
    end

    // Final byte: flush what is open, report end of file unless an error was found, start a new source.
    if (fin) begin
      if (mode_r != MODE_ERROR) begin
        if (mode_nxt == MODE_SLASH) begin
          cvld[2] = 1'b1;
          cand[2] = mk(KIND_LPAREN, ERR_SLASH, rs_nxt, POSITION_BITS'(1), line_nxt);
        end else if (mode_nxt != MODE_ERROR) begin
          if (mode_nxt == MODE_NUMBER) begin
            cvld[2] = 1'b1;
            cand[2] = mk(KIND_NUMBER, ERR_NONE, rs_nxt, rl_nxt, line_nxt);
          end else if (mode_nxt == MODE_IDENT) begin
            cvld[2] = 1'b1;
            cand[2] = mk(classify(kw_nxt, rl_nxt), ERR_NONE, rs_nxt, rl_nxt, line_nxt);
          end
          cvld[3] = 1'b1;
          cand[3] = mk(KIND_EOF, ERR_NONE, pos_inc, '0, line_nxt);
        end
      end
      mode_nxt = MODE_IDLE;
      pos_nxt  = '0;
      rs_nxt   = '0;
      rl_nxt   = '0;
      line_nxt = first_line_r;
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        kw_nxt[i] = '0;
      end
    end
  end

  // Pack the valid candidates into the first slots and flag the last one.
  always_comb begin
    slots = '0;
    n     = '0;
    for (int i = 0; i < 4; i++) begin
      if (cvld[i]) begin
        if (n < 3'd3) slots[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    cnt = n[2] ? 2'd3 : n[1:0];
    if (cnt != 2'd0) slots[cnt - 2'd1].last_of_run = 1'b1;
  end

  assign bundle.load  = step && (cnt != 2'd0);
  assign bundle.count = cnt;
  assign bundle.res   = slots;
  assign first_line   = first_line_r;

  // Scanner state and the first line register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      pos_r        <= '0;
      rs_r         <= '0;
      rl_r         <= '0;
      line_r       <= FIRST_LINE_RESET;
      first_line_r <= FIRST_LINE_RESET;
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        kw_r[i] <= '0;
      end
    end else begin
      if (cfg.we) first_line_r <= cfg.value;
      if (step) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        rs_r   <= rs_nxt;
        rl_r   <= rl_nxt;
        line_r <= line_nxt;
        kw_r   <= kw_nxt;
      end else if (cfg.we && mode_r == MODE_IDLE && pos_r == '0) begin
        line_r <= cfg.value;
      end
    end
  end

endmodule

// ===== sv/kwl_outbuf.sv =====
module kwl_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  kwl_pkg::bundle_t    bundle,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output kwl_pkg::out_item_t  out_data
);
  import kwl_pkg::*;

  out_item_t [2:0] res_r;
  logic [1:0]      rem_r, rem_nxt;
  logic [1:0]      hd_r, hd_nxt;
  logic            out_acc;

  assign out_valid = (rem_r != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  // Room for a new set of results once the last one held leaves this cycle.
  assign free      = (rem_r == 2'd0) || (rem_r == 2'd1 && !out_stall);

  // Result selection at the read pointer.
  always_comb begin
    case (hd_r)
      2'd1:    out_data = res_r[1];
      2'd2:    out_data = res_r[2];
      default: out_data = res_r[0];
    endcase
  end

  // Count of results still to deliver and the read pointer.
  always_comb begin
    rem_nxt = rem_r;
    hd_nxt  = hd_r;
    if (bundle.load) begin
      rem_nxt = bundle.count;
      hd_nxt  = 2'd0;
    end else if (out_acc) begin
      rem_nxt = rem_r - 2'd1;
      hd_nxt  = hd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      hd_r  <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      hd_r  <= hd_nxt;
    end
  end

  // Result payload, loaded only when a new set arrives.
  always_ff @(posedge clk) begin
    if (bundle.load) res_r <= bundle.res;
  end

endmodule

// ===== sv/keyword_token_lexer.sv =====
// Path: an accepted item waits in the input register until the output buffer is free,
// is scanned combinationally, and its results are registered in the output buffer.
// Throughput: one byte per cycle while no byte yields more than one result and out_stall
// is low; otherwise the input is held until the last result leaves the output buffer.
// Reset: synchronous, active low; clears scanner state, sets the first line number to 1.
module keyword_token_lexer #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kwl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kwl_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import kwl_pkg::*;

  in_item_t    in_r;
  logic        in_vld_r, in_vld_nxt;
  logic        fire, free, in_acc;
  bundle_t     bundle;
  cfg_wr_t     cfg;
  logic [15:0] first_line;

  // Input register: takes a new item when empty or when its item moves on to the scanner.
  assign fire     = in_vld_r && free;
  assign in_stall = in_vld_r && !free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_r <= in_data;
  end

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg.we    = psel && penable && pwrite && (paddr[2] == REG_FIRST_LINE);
  assign cfg.value = pwdata[15:0];
  assign prdata    = (paddr[2] == REG_FIRST_LINE) ? {16'b0, first_line} : 32'b0;

  kwl_core #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .item      (in_r),
    .cfg       (cfg),
    .bundle    (bundle),
    .first_line(first_line)
  );

  kwl_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .bundle   (bundle),
    .free     (free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // A scanned byte with results puts a result on the output next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    bundle.load |=> out_valid)
    else $error("results of a scanned item not offered");

  // A held input item is never overwritten before it is scanned.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !fire) |=> (in_vld_r && $stable(in_r)))
    else $error("input register lost an item");

  // Error results are one byte long and carry kind zero.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != ERR_NONE) |->
      (out_data.token_kind == KIND_LPAREN && out_data.token_length == 16'd1))
    else $error("malformed error result");

  // End of file is always the last result of its byte and has no length.
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.token_kind == KIND_EOF) |->
      (out_data.last_of_run && out_data.token_length == 16'd0))
    else $error("end of file result not last or not empty");
`endif

endmodule
